// ----- sv/rbs_pkg.sv -----
// rbs_pkg: widths, fixed-point constants and sideband types for the ray/box slab test
// no dependencies; imported by rbs_div, ray_box_slab_intersection, rbs_checker and the test bench
package rbs_pkg;

  localparam int CW     = 32;   // coordinate width, signed fixed point
  localparam int FRAC   = 16;   // fractional bits
  localparam int EPS_W  = 16;   // parallel epsilon register width
  localparam int NAX    = 3;    // axes
  localparam int NLANE  = 2 * NAX;  // one divider lane per slab plane
  localparam int NST    = CW + 5;   // prep, CW divide steps, finalize, order, reduce, output

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW:0]          mag_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  // per-axis info that rides along the divider pipeline
  typedef struct packed {
    logic par;
    logic pmiss;
    logic neg_lo;
    logic neg_hi;
    logic ovf_lo;
    logic ovf_hi;
  } axis_sb_t;

endpackage

// ----- sv/rbs_div.sv -----
// rbs_div: pipelined restoring divider, one quotient bit per stage
// depends on rbs_pkg; caller supplies the initial remainder and the dividend bits to shift in
module rbs_div (
  input  logic                  clk_i,
  input  logic [rbs_pkg::CW-1:0] en_i,
  input  rbs_pkg::mag_t         rem_i,
  input  logic [rbs_pkg::CW-1:0] bits_i,
  input  logic [rbs_pkg::CW-1:0] den_i,
  output logic [rbs_pkg::CW-1:0] quo_o
);
  import rbs_pkg::*;

  mag_t           rem_q  [CW];
  logic [CW-1:0]  bits_q [CW];
  logic [CW-1:0]  quo_q  [CW];
  logic [CW-1:0]  den_q  [CW];

  for (genvar s = 0; s < CW; s++) begin : g_st
    mag_t          rin;
    logic [CW-1:0] bin;
    logic [CW-1:0] qin;
    logic [CW-1:0] din;
    mag_t          r2;
    logic          ge;

    if (s == 0) begin : g_first
      assign rin = rem_i;
      assign bin = bits_i;
      assign qin = '0;
      assign din = den_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign bin = bits_q[s-1];
      assign qin = quo_q[s-1];
      assign din = den_q[s-1];
    end

    // remainder stays below the divisor, so the top bit is free for the shift
    assign r2 = {rin[CW-1:0], bin[CW-1]};
    assign ge = (r2 >= {1'b0, din});

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= ge ? (r2 - {1'b0, din}) : r2;
        bits_q[s] <= {bin[CW-2:0], 1'b0};
        quo_q[s]  <= {qin[CW-2:0], ge};
        den_q[s]  <= din;
      end
    end
  end

  assign quo_o = quo_q[CW-1];

endmodule

// ----- sv/ray_box_slab_intersection.sv -----
// ray_box_slab_intersection: streaming ray versus axis-aligned box test, slab method
// depends on rbs_pkg and rbs_div (six lanes, one per slab plane)
//
//   channel   signals                               carries
//   in        in_valid_i / in_ready_o               ray origin, direction, box corners
//   out       out_valid_o / out_ready_i             hit, distance, from_inside
//   cfg       cfg_we_i / cfg_wdata_i                parallel epsilon
//
// one request per cycle sustained while the output is taken; CW+5 = 37 register
// stages, CW of them in the one-bit-per-stage divider lanes. reset clears the
// stage valid bits and sets epsilon to 1. each stage holds only when it is
// full and the stage after it holds, so bubbles close up while the output waits.
module ray_box_slab_intersection (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rbs_pkg::coord_t         origin_x_i,
  input  rbs_pkg::coord_t         origin_y_i,
  input  rbs_pkg::coord_t         origin_z_i,
  input  rbs_pkg::coord_t         dir_x_i,
  input  rbs_pkg::coord_t         dir_y_i,
  input  rbs_pkg::coord_t         dir_z_i,
  input  rbs_pkg::coord_t         box_min_x_i,
  input  rbs_pkg::coord_t         box_min_y_i,
  input  rbs_pkg::coord_t         box_min_z_i,
  input  rbs_pkg::coord_t         box_max_x_i,
  input  rbs_pkg::coord_t         box_max_y_i,
  input  rbs_pkg::coord_t         box_max_z_i,
  input  logic                    cfg_we_i,
  input  logic [rbs_pkg::EPS_W-1:0] cfg_wdata_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output rbs_pkg::coord_t         distance_o,
  output logic                    from_inside_o
);
  import rbs_pkg::*;

  localparam int SF = CW + 1;  // finalize
  localparam int SO = CW + 2;  // order per axis
  localparam int SR = CW + 3;  // reduce
  localparam int SX = CW + 4;  // output

  logic [EPS_W-1:0] eps_q;
  logic [NST-1:0]   v_q;
  logic [NST-1:0]   en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(1);
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // stage enables: load when empty or when the next stage moves
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  // ---- prep: differences, magnitudes, parallel test, overflow test
  coord_t o_in  [NAX];
  coord_t d_in  [NAX];
  coord_t lo_in [NAX];
  coord_t hi_in [NAX];

  assign o_in  = '{origin_x_i, origin_y_i, origin_z_i};
  assign d_in  = '{dir_x_i, dir_y_i, dir_z_i};
  assign lo_in = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi_in = '{box_max_x_i, box_max_y_i, box_max_z_i};

  mag_t          p_rem  [NLANE];
  logic [CW-1:0] p_bits [NLANE];
  logic [CW-1:0] p_den  [NAX];
  axis_sb_t      p_sb   [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      logic signed [CW:0] dlo;
      logic signed [CW:0] dhi;
      mag_t               nlo;
      mag_t               nhi;
      logic [CW-1:0]      dm;
      dlo = {lo_in[a][CW-1], lo_in[a]} - {o_in[a][CW-1], o_in[a]};
      dhi = {hi_in[a][CW-1], hi_in[a]} - {o_in[a][CW-1], o_in[a]};
      nlo = dlo[CW] ? mag_t'(-dlo) : mag_t'(dlo);
      nhi = dhi[CW] ? mag_t'(-dhi) : mag_t'(dhi);
      dm  = d_in[a][CW-1] ? (CW)'(-d_in[a]) : d_in[a];
      p_den[a] = dm;
      p_sb[a].par    = (dm == '0) || (dm < {{(CW-EPS_W){1'b0}}, eps_q});
      p_sb[a].pmiss  = (o_in[a] < lo_in[a]) || (o_in[a] > hi_in[a]);
      p_sb[a].neg_lo = dlo[CW] ^ d_in[a][CW-1];
      p_sb[a].neg_hi = dhi[CW] ^ d_in[a][CW-1];
      // quotient reaches 2^CW when the top part of the dividend is not below the divisor
      p_sb[a].ovf_lo = ({{(CW-FRAC-1){1'b0}}, nlo[CW:CW-FRAC]} >= dm);
      p_sb[a].ovf_hi = ({{(CW-FRAC-1){1'b0}}, nhi[CW:CW-FRAC]} >= dm);
      p_rem[2*a]      = {{(CW-FRAC){1'b0}}, nlo[CW:CW-FRAC]};
      p_rem[2*a+1]    = {{(CW-FRAC){1'b0}}, nhi[CW:CW-FRAC]};
      p_bits[2*a]     = {nlo[CW-FRAC-1:0], {FRAC{1'b0}}};
      p_bits[2*a+1]   = {nhi[CW-FRAC-1:0], {FRAC{1'b0}}};
    end
  end

  mag_t          pr_rem_q  [NLANE];
  logic [CW-1:0] pr_bits_q [NLANE];
  logic [CW-1:0] pr_den_q  [NAX];
  axis_sb_t      sb_q      [CW+1][NAX];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pr_rem_q  <= p_rem;
      pr_bits_q <= p_bits;
      pr_den_q  <= p_den;
      sb_q[0]   <= p_sb;
    end
    for (int k = 1; k <= CW; k++) begin
      if (en[k]) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // ---- divider lanes
  logic [CW-1:0] quo [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    rbs_div u_div (
      .clk_i  (clk_i),
      .en_i   (en[CW:1]),
      .rem_i  (pr_rem_q[l]),
      .bits_i (pr_bits_q[l]),
      .den_i  (pr_den_q[l/2]),
      .quo_o  (quo[l])
    );
  end

  // ---- finalize: saturate and apply sign
  coord_t   t_q   [NLANE];
  axis_sb_t sbf_q [NAX];

  always_ff @(posedge clk_i) begin
    if (en[SF]) begin
      for (int l = 0; l < NLANE; l++) begin
        logic          neg;
        logic          ovf;
        logic [CW-1:0] lim;
        logic [CW-1:0] res;
        neg = (l % 2 == 0) ? sb_q[CW][l/2].neg_lo : sb_q[CW][l/2].neg_hi;
        ovf = (l % 2 == 0) ? sb_q[CW][l/2].ovf_lo : sb_q[CW][l/2].ovf_hi;
        lim = neg ? CMIN : CMAX;
        res = (ovf || (quo[l] > lim)) ? lim : quo[l];
        t_q[l] <= neg ? coord_t'(-res) : coord_t'(res);
      end
      sbf_q <= sb_q[CW];
    end
  end

  // ---- order per axis; parallel axes leave entry and exit alone
  coord_t near_q [NAX];
  coord_t far_q  [NAX];
  logic   pm_o_q;

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      for (int a = 0; a < NAX; a++) begin
        if (sbf_q[a].par) begin
          near_q[a] <= CMIN;
          far_q[a]  <= CMAX;
        end else if (t_q[2*a] > t_q[2*a+1]) begin
          near_q[a] <= t_q[2*a+1];
          far_q[a]  <= t_q[2*a];
        end else begin
          near_q[a] <= t_q[2*a];
          far_q[a]  <= t_q[2*a+1];
        end
      end
      pm_o_q <= (sbf_q[0].par && sbf_q[0].pmiss) || (sbf_q[1].par && sbf_q[1].pmiss) ||
                (sbf_q[2].par && sbf_q[2].pmiss);
    end
  end

  // ---- reduce: entry is the largest near value, exit the smallest far value
  coord_t ent_q;
  coord_t ext_q;
  logic   pm_r_q;

  always_ff @(posedge clk_i) begin
    if (en[SR]) begin
      coord_t e01;
      coord_t x01;
      e01 = (near_q[0] > near_q[1]) ? near_q[0] : near_q[1];
      x01 = (far_q[0] < far_q[1]) ? far_q[0] : far_q[1];
      ent_q  <= (e01 > near_q[2]) ? e01 : near_q[2];
      ext_q  <= (x01 < far_q[2]) ? x01 : far_q[2];
      pm_r_q <= pm_o_q;
    end
  end

  // ---- output register
  logic   hit_q;
  logic   inside_q;
  coord_t dist_q;

  always_ff @(posedge clk_i) begin
    if (en[SX]) begin
      logic miss;
      miss = pm_r_q || (ent_q > ext_q);
      hit_q    <= 1'b0;
      inside_q <= 1'b0;
      dist_q   <= '0;
      if (!miss) begin
        if (ent_q > 0) begin
          hit_q  <= 1'b1;
          dist_q <= ent_q;
        end else if (ext_q > 0) begin
          hit_q    <= 1'b1;
          inside_q <= 1'b1;
          dist_q   <= ext_q;
        end
      end
    end
  end

  assign out_valid_o   = v_q[NST-1];
  assign hit_o         = hit_q;
  assign distance_o    = dist_q;
  assign from_inside_o = inside_q;

endmodule

// ----- sv/rbs_checker.sv -----
// rbs_checker: port-level checks on result consistency and the output handshake
// depends on rbs_pkg; bound to ray_box_slab_intersection at the end of this file
module rbs_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            hit_o,
  input rbs_pkg::coord_t distance_o,
  input logic            from_inside_o
);
  import rbs_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(hit_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> distance_o == '0 && !from_inside_o)
    else $error("miss with nonzero distance or inside flag");

  a_hit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> distance_o > 0)
    else $error("hit with non-positive distance");

  a_inside_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_inside_o |-> hit_o)
    else $error("inside flag without hit");

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_o         (hit_o),
  .distance_o    (distance_o),
  .from_inside_o (from_inside_o)
);

// ----- verif/ray_box_slab_intersection_test.sv -----
// ray_box_slab_intersection_test: self-checking bench for the ray/box slab intersection block
// depends on rbs_pkg and ray_box_slab_intersection; no other files
module ray_box_slab_intersection_test;
  import rbs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = NST + 20;
  localparam coord_t Q1 = 32'sh0001_0000;

  typedef struct packed {
    coord_t ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz;
  } ray_box_t;

  typedef struct packed {
    logic   hit;
    coord_t tval;
    logic   from_in;
  } hit_info_t;

  typedef struct {
    ray_box_t  rb;
    logic      known;
    hit_info_t res;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  ray_box_t req;
  logic cfg_we_i;
  logic [EPS_W-1:0] cfg_wdata_i;
  logic hit_o, from_inside_o;
  coord_t distance_o;

  logic [EPS_W-1:0] eps_model;
  hit_info_t expected_hits[$];
  int mismatches, cycles;
  int send_idle_pct, recv_idle_pct;
  stim_row_t directed[$];

  ray_box_slab_intersection u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .origin_x_i(req.ox), .origin_y_i(req.oy), .origin_z_i(req.oz),
    .dir_x_i(req.dx), .dir_y_i(req.dy), .dir_z_i(req.dz),
    .box_min_x_i(req.lx), .box_min_y_i(req.ly), .box_min_z_i(req.lz),
    .box_max_x_i(req.hx), .box_max_y_i(req.hy), .box_max_z_i(req.hz),
    .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_ready_i,
    .hit_o, .distance_o, .from_inside_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // (num << 16) / den, truncated toward zero, saturated to the coordinate range
  function automatic longint slab_quotient(longint num, longint den);
    longint unsigned n, d, lim, q, r, res;
    logic neg;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    q = n / d;
    r = n % d;
    if (q > (lim >> FRAC)) res = lim;
    else begin
      res = (q << FRAC) + ((r << FRAC) / d);
      if (res > lim) res = lim;
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic hit_info_t slab_hit(ray_box_t rb, logic [EPS_W-1:0] eps);
    coord_t o[3], d[3], lo[3], hi[3];
    longint entry, exitd, t1, t2, t, od, dd, ad;
    logic miss;
    hit_info_t r;
    o = '{rb.ox, rb.oy, rb.oz};
    d = '{rb.dx, rb.dy, rb.dz};
    lo = '{rb.lx, rb.ly, rb.lz};
    hi = '{rb.hx, rb.hy, rb.hz};
    entry = -64'sd2147483648;
    exitd = 64'sd2147483647;
    miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!miss) begin
        od = o[a];
        dd = d[a];
        ad = dd < 0 ? -dd : dd;
        if (dd == 0 || ad < longint'(eps)) begin
          if (od < longint'(lo[a]) || od > longint'(hi[a])) miss = 1'b1;
        end else begin
          t1 = slab_quotient(longint'(lo[a]) - od, dd);
          t2 = slab_quotient(longint'(hi[a]) - od, dd);
          if (t1 > t2) begin
            t = t1; t1 = t2; t2 = t;
          end
          if (t1 > entry) entry = t1;
          if (t2 < exitd) exitd = t2;
          if (entry > exitd) miss = 1'b1;
        end
      end
    end
    r = '0;
    if (!miss) begin
      if (entry > 0) begin
        r.hit = 1'b1; r.tval = coord_t'(entry);
      end else if (exitd > 0) begin
        r.hit = 1'b1; r.tval = coord_t'(exitd); r.from_in = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8) * 32'h0001_0000) - 4 * Q1;
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      3: return coord_t'($urandom_range(0, 3)) - 1;
      default: return coord_t'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  // mostly rays aimed near a small box, some pure noise
  function automatic ray_box_t rand_ray();
    ray_box_t rb;
    coord_t c, e;
    rb = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord()};
    if ($urandom_range(0, 9) < 7) begin
      c = coord_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      e = coord_t'($urandom_range(0, 2 ** 18));
      rb.lx = c - e; rb.hx = c + e;
      rb.ly = c - e + Q1; rb.hy = c + e + Q1;
      rb.lz = c - e - Q1; rb.hz = c + e;
      rb.ox = c - 8 * e; rb.oy = c + coord_t'($urandom_range(0, 2 ** 16));
      rb.oz = c;
      rb.dx = coord_t'($urandom_range(1, 2 ** 17));
      rb.dy = coord_t'($urandom_range(0, 40)) - 20;
      rb.dz = coord_t'(int'($urandom_range(0, 2 ** 12)) - 2 ** 11);
      if ($urandom_range(0, 3) == 0) rb.ox = c;
    end
    return rb;
  endfunction

  // valid stays up between back-to-back requests; it drops only on idle cycles
  task automatic send_ray(ray_box_t rb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req <= rb;
    expected_hits.push_back(slab_hit(rb, eps_model));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    while (n < DRAIN_CYCLES) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic set_epsilon(logic [EPS_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    eps_model = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result hit=%0b dist=%0d", hit_o, distance_o);
        end else begin
          hit_info_t e;
          e = expected_hits.pop_front();
          if (hit_o !== e.hit || distance_o !== e.tval || from_inside_o !== e.from_in) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b dist=%0d inside=%0b, got hit=%0b dist=%0d inside=%0b",
                       e.hit, e.tval, e.from_in, hit_o, distance_o, from_inside_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic stim_row_t row(ray_box_t rb, logic known, hit_info_t res);
    stim_row_t s;
    s.rb = rb; s.known = known; s.res = res;
    return s;
  endfunction

  initial begin
    hit_info_t no_hit, unk;
    ray_box_t unit_box, rb;
    no_hit = '0;
    unk = '0;
    cycles = 0; mismatches = 0;
    send_idle_pct = 11; recv_idle_pct = 55;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0; req = '0;
    eps_model = 16'd1;
    // origin at -2 on x, aimed along +x at box [-1,1]^3
    unit_box = {-2 * Q1, 32'sd0, 32'sd0, Q1, 32'sd0, 32'sd0,
                -Q1, -Q1, -Q1, Q1, Q1, Q1};
    directed.push_back(row(unit_box, 1'b1, '{1'b1, Q1, 1'b0}));
    rb = unit_box; rb.ox = 0;
    directed.push_back(row(rb, 1'b1, '{1'b1, Q1, 1'b1}));
    rb = unit_box; rb.ox = 4 * Q1;
    directed.push_back(row(rb, 1'b1, no_hit));
    rb = unit_box; rb.oy = 2 * Q1;
    directed.push_back(row(rb, 1'b1, no_hit));
    rb = unit_box; rb.ox = Q1;
    directed.push_back(row(rb, 1'b1, no_hit));
    // all axes parallel with origin in the box: exit stays at the top value
    rb = unit_box; rb.dx = 0; rb.ox = 0;
    directed.push_back(row(rb, 1'b1, '{1'b1, CMAX, 1'b1}));
    rb = unit_box; rb.lx = Q1; rb.hx = -Q1; rb.dx = 0;
    directed.push_back(row(rb, 1'b1, no_hit));
    rb = unit_box; rb.lx = Q1; rb.hx = -Q1;
    directed.push_back(row(rb, 1'b0, unk));
    rb = unit_box; rb.dx = 1;
    directed.push_back(row(rb, 1'b1, '{1'b1, CMAX, 1'b0}));
    rb = unit_box; rb.ox = CMIN; rb.dx = CMAX;
    directed.push_back(row(rb, 1'b0, unk));
    rb = unit_box; rb.ox = CMAX; rb.dx = CMIN;
    directed.push_back(row(rb, 1'b0, unk));
    rb = '{ox: CMIN, oy: CMAX, oz: CMIN, dx: CMAX, dy: CMIN, dz: -1,
           lx: CMIN, ly: CMIN, lz: CMIN, hx: CMAX, hy: CMAX, hz: CMAX};
    directed.push_back(row(rb, 1'b0, unk));
    rb = '1;
    directed.push_back(row(rb, 1'b0, unk));
    rb = unit_box; rb.dx = -Q1; rb.ox = 3 * Q1;
    directed.push_back(row(rb, 1'b1, '{1'b1, 2 * Q1, 1'b0}));
    rb = unit_box; rb.dx = 3 * Q1; rb.dy = -7; rb.dz = 5;
    directed.push_back(row(rb, 1'b0, unk));
    rb = unit_box; rb.ox = -Q1;
    directed.push_back(row(rb, 1'b1, '{1'b1, 2 * Q1, 1'b1}));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].known && slab_hit(directed[i].rb, eps_model) != directed[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("predictor disagrees with table row %0d", i);
      end
      send_ray(directed[i].rb);
    end
    wait_idle();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_epsilon(16'd0);
        1: set_epsilon(16'hFFFF);
        2: set_epsilon(16'd16);
        3: set_epsilon(16'(($urandom)));
        default: set_epsilon(16'd1);
      endcase
      if (phase == 2) begin
        send_idle_pct = 55; recv_idle_pct = 11;
      end
      if (phase == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 367; n++) send_ray(rand_ray());
      wait_idle();
    end
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
